// ===== rtl/core/legarc_pkg.sv =====
// legarc_pkg: shared types and constants of the leg arc trajectory generator
// controller command and status structs, state and job encodings
// no dependencies
`timescale 1ns / 1ps

package legarc_pkg;

  localparam int STEP_W    = 7;
  localparam int IDX_W     = 6;
  localparam int HOP_W     = 20;
  localparam int AMP_W     = 32;
  localparam int SINE_W    = 16;
  localparam int PHASE_W   = 17;
  localparam int DIVISOR_W = 23;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  localparam logic [HOP_W-1:0]   HOP_RESET  = 20'd25000;
  localparam logic [63:0]        PI_HALF_Q30 = 64'd1686629713;
  localparam logic [PHASE_W-1:0] PHASE_ONE  = 17'd65536;
  localparam logic [PHASE_W-1:0] PHASE_HALF = 17'd32768;
  localparam logic [15:0]        HALF_Q15   = 16'd16384;

  // register index taken from paddr[2]
  localparam logic REG_HOP = 1'b0;

  // square-and-accumulate sweep: four squares, then a final accumulate
  localparam logic [2:0] SQ_LAST = 3'd4;

  typedef enum logic [1:0] {
    SQ_X,
    SQ_Y,
    SQ_Z,
    SQ_H
  } sq_sel_t;

  typedef enum logic [2:0] {
    DJ_X,
    DJ_Y,
    DJ_Z,
    DJ_PHASE,
    DJ_AMP
  } div_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_PH_MUL,
    ST_ROM,
    ST_ARC,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic     load;
    logic     sq_en;
    sq_sel_t  sq_sel;
    logic     acc_en;
    logic     acc_h;
    logic     div_start;
    div_job_t div_job;
    logic     ph_mul;
    logic     rom_rd;
    logic     arc_mul;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic last;
    logic div_done;
  } dp_status_t;

endpackage

// ===== rtl/core/legarc_div.sv =====
// legarc_div: restoring divider, one quotient bit per cycle
// does not import legarc_pkg; standalone unit
`timescale 1ns / 1ps

module legarc_div #(
  parameter int DW = 53,
  parameter int VW = 23
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            busy;

  logic [VW:0] rem_sh;
  logic [VW:0] rem_sub;
  logic        ge;

  assign rem_sh  = {rem, quo[DW-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== rtl/core/legarc_dp.sv =====
// legarc_dp: datapath - move registers, squarer, shared divider, incremental
// interpolators, phase accumulator, sine table and arc multiplier
// depends on legarc_pkg and legarc_div
`timescale 1ns / 1ps

module legarc_dp
  import legarc_pkg::*;
#(
  parameter int POINT_LIMIT      = 64,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int COORD_BITS       = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] goal_x,
  input  logic signed [COORD_BITS-1:0] goal_y,
  input  logic signed [COORD_BITS-1:0] goal_z,
  input  logic [STEP_W-1:0]            step_count,
  input  logic                         arc_enable,
  input  logic [HOP_W-1:0]             hop_h,
  input  dp_cmd_t                      cmd,
  output dp_status_t                   status,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  output logic [IDX_W-1:0]             point_index,
  output logic                         last_point
);

  localparam int C    = COORD_BITS;
  localparam int MW   = C + 1;                       // axis delta magnitude
  localparam int CW   = (C + 1 > 32) ? 32 : C + 1;   // clamped magnitude
  localparam int SOW  = (CW > HOP_W) ? CW : HOP_W;
  localparam int PW   = 2 * SOW;
  localparam int NUMW = PW + 3;
  localparam int LW   = C + 2;                       // straight-line coordinate
  localparam int ARCW = 34;
  localparam int ZW   = ((LW > ARCW + 1) ? LW : ARCW + 1) + 1;
  localparam int KW   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int KPW  = 16 + KW;
  localparam int RW   = STEP_W + 1;

  localparam logic [STEP_W-1:0] NMAX =
    (POINT_LIMIT > 127) ? 7'd127 : STEP_W'(POINT_LIMIT);
  localparam logic signed [ZW-1:0] CMAX =
    $signed({{(ZW - C + 1){1'b0}}, {(C - 1){1'b1}}});
  localparam logic signed [ZW-1:0] CMIN = -CMAX - 1;

  function automatic logic [SINE_W-1:0] quarter_sine(input logic [31:0] k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x   = PI_HALF_Q30 * 64'(k) / 64'(SINE_TABLE_DEPTH);
    x2  = (x * x) >> 30;
    t   = x;
    sum = $signed(x);
    t = ((t * x2) >> 30) / 64'd6;   sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd20;  sum = sum + $signed(t);
    t = ((t * x2) >> 30) / 64'd42;  sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd72;  sum = sum + $signed(t);
    t = ((t * x2) >> 30) / 64'd110; sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd156; sum = sum + $signed(t);
    t = ((t * x2) >> 30) / 64'd210; sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd272; sum = sum + $signed(t);
    if (sum < 0) sum = 0;
    r = ($unsigned(sum) + 64'd16384) >> 15;
    if (r > 64'd32768) r = 64'd32768;
    return r[SINE_W-1:0];
  endfunction

  function automatic logic signed [C-1:0] sat_c(input logic signed [ZW-1:0] v);
    logic signed [ZW-1:0] w;
    w = v;
    if (w > CMAX) w = CMAX;
    if (w < CMIN) w = CMIN;
    return w[C-1:0];
  endfunction

  // per-axis lanes
  logic signed [C-1:0] start_a [3];
  logic signed [C-1:0] goal_a  [3];
  logic signed [C-1:0] s_a     [3];
  logic                neg_a   [3];
  logic [MW-1:0]       mag_a   [3];
  logic [MW-1:0]       quo_a   [3];
  logic [RW-1:0]       rinc_a  [3];
  logic [MW-1:0]       q_a     [3];
  logic [RW-1:0]       r_a     [3];
  logic signed [LW-1:0] line_a [3];
  logic [CW-1:0]       clamp_a [3];

  assign start_a[0] = start_x;
  assign start_a[1] = start_y;
  assign start_a[2] = start_z;
  assign goal_a[0]  = goal_x;
  assign goal_a[1]  = goal_y;
  assign goal_a[2]  = goal_z;

  logic [STEP_W-1:0]  n;
  logic               arc;
  logic [STEP_W-1:0]  idx;
  logic [STEP_W-1:0]  nclamp;
  logic [PW-1:0]      prod;
  logic [NUMW-1:0]    num;
  logic [PHASE_W-1:0] ph;
  logic [PHASE_W-1:0] ph_inc;
  logic [STEP_W-1:0]  rp;
  logic [STEP_W-1:0]  rp_inc;
  logic [AMP_W-1:0]   amp;
  logic [KPW-1:0]     kprod;
  logic [SINE_W-1:0]  sn;
  logic [47:0]        arcprod;

  assign nclamp = (step_count > NMAX) ? NMAX : step_count;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [MW-1:0] d;
    logic [63:0]          m64;
    logic [RW:0]          r_sum;
    logic [RW:0]          two_n;

    assign d   = MW'(goal_a[a]) - MW'(start_a[a]);
    assign m64 = 64'(mag_a[a]);
    assign clamp_a[a] = (m64 > 64'h8000_0000) ? CW'(64'h8000_0000) : CW'(m64);
    assign r_sum = {1'b0, r_a[a]} + {1'b0, rinc_a[a]};
    assign two_n = {1'b0, n, 1'b0};
    assign line_a[a] = neg_a[a] ? ($signed({{2{s_a[a][C-1]}}, s_a[a]}) - $signed({1'b0, q_a[a]}))
                                : ($signed({{2{s_a[a][C-1]}}, s_a[a]}) + $signed({1'b0, q_a[a]}));

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        s_a[a]   <= start_a[a];
        neg_a[a] <= d[MW-1];
        mag_a[a] <= d[MW-1] ? MW'(-d) : MW'(d);
        q_a[a]   <= '0;
        r_a[a]   <= RW'(nclamp);
      end else if (cmd.emit) begin
        // q tracks round(mag * i / n); r is the running remainder against 2n
        if (r_sum >= two_n) begin
          r_a[a] <= RW'(r_sum - two_n);
          q_a[a] <= q_a[a] + quo_a[a] + MW'(1);
        end else begin
          r_a[a] <= RW'(r_sum);
          q_a[a] <= q_a[a] + quo_a[a];
        end
      end
    end
  end

  // divider operand selection
  logic [NUMW-1:0]      div_dividend;
  logic [DIVISOR_W-1:0] div_divisor;
  logic                 div_done;
  logic [NUMW-1:0]      div_quo;
  logic [DIVISOR_W-1:0] div_rem;

  always_comb begin
    div_divisor = DIVISOR_W'(n);
    case (cmd.div_job)
      DJ_X:     div_dividend = NUMW'(mag_a[0]);
      DJ_Y:     div_dividend = NUMW'(mag_a[1]);
      DJ_Z:     div_dividend = NUMW'(mag_a[2]);
      DJ_PHASE: div_dividend = NUMW'(PHASE_ONE);
      default: begin
        div_dividend = num;
        div_divisor  = {hop_h, 3'b000};
      end
    endcase
  end

  legarc_div #(
    .DW(NUMW),
    .VW(DIVISOR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_job)
        DJ_X: begin
          quo_a[0]  <= MW'(div_quo);
          rinc_a[0] <= {div_rem[STEP_W-1:0], 1'b0};
        end
        DJ_Y: begin
          quo_a[1]  <= MW'(div_quo);
          rinc_a[1] <= {div_rem[STEP_W-1:0], 1'b0};
        end
        DJ_Z: begin
          quo_a[2]  <= MW'(div_quo);
          rinc_a[2] <= {div_rem[STEP_W-1:0], 1'b0};
        end
        DJ_PHASE: begin
          ph_inc <= PHASE_W'(div_quo);
          rp_inc <= div_rem[STEP_W-1:0];
        end
        default: begin
          if (!arc) amp <= '0;
          else if (|div_quo[NUMW-1:AMP_W]) amp <= '1;
          else amp <= div_quo[AMP_W-1:0];
        end
      endcase
    end
  end

  // squared distance plus 4h^2
  logic [SOW-1:0] sq_op;

  always_comb begin
    case (cmd.sq_sel)
      SQ_X:    sq_op = SOW'(clamp_a[0]);
      SQ_Y:    sq_op = SOW'(clamp_a[1]);
      SQ_Z:    sq_op = SOW'(clamp_a[2]);
      default: sq_op = SOW'(hop_h);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) prod <= PW'(sq_op) * PW'(sq_op);
    if (cmd.load) begin
      num <= '0;
    end else if (cmd.acc_en) begin
      num <= num + (cmd.acc_h ? (NUMW'(prod) << 2) : NUMW'(prod));
    end
  end

  // move control registers and phase accumulator
  logic [STEP_W:0] rp_sum;
  assign rp_sum = {1'b0, rp} + {1'b0, rp_inc};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n   <= nclamp;
      arc <= arc_enable;
      idx <= '0;
      ph  <= '0;
      rp  <= '0;
    end else if (cmd.emit) begin
      idx <= idx + STEP_W'(1);
      if (rp_sum >= {1'b0, n}) begin
        rp <= STEP_W'(rp_sum - {1'b0, n});
        ph <= ph + ph_inc + PHASE_W'(1);
      end else begin
        rp <= STEP_W'(rp_sum);
        ph <= ph + ph_inc;
      end
    end
  end

  // sine lookup and arc term
  logic [PHASE_W-1:0] u17;
  logic [KPW:0]       k_round;
  logic [KW-1:0]      kidx;
  logic [SINE_W-1:0]  sine_rom [SINE_TABLE_DEPTH+1];
  logic [48:0]        arc_round;
  logic [ARCW-1:0]    arc_term;

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = quarter_sine(32'(g));
  end

  assign u17       = (ph <= PHASE_HALF) ? ph : PHASE_ONE - ph;
  assign k_round   = {1'b0, kprod} + (KPW + 1)'(HALF_Q15);
  assign kidx      = k_round[15 +: KW];
  assign arc_round = {1'b0, arcprod} + 49'(HALF_Q15);
  assign arc_term  = arc_round[48:15];

  always_ff @(posedge clk) begin
    if (cmd.ph_mul)  kprod   <= KPW'(u17[15:0]) * KPW'(SINE_TABLE_DEPTH);
    if (cmd.rom_rd)  sn      <= sine_rom[kidx];
    if (cmd.arc_mul) arcprod <= 48'(amp) * 48'(sn);
  end

  // output register
  logic signed [ZW-1:0] z_sum;
  assign z_sum = ZW'(line_a[2]) + $signed({{(ZW - ARCW){1'b0}}, arc_term});

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      point_x     <= sat_c(ZW'(line_a[0]));
      point_y     <= sat_c(ZW'(line_a[1]));
      point_z     <= sat_c(z_sum);
      point_index <= idx[IDX_W-1:0];
      last_point  <= status.last;
    end
  end

  assign status.n_zero   = step_count == '0;
  assign status.last     = (idx + STEP_W'(1)) == n;
  assign status.div_done = div_done;

endmodule

// ===== rtl/core/legarc_ctrl.sv =====
// legarc_ctrl: move sequencer - setup sweep, divide jobs, per-point stages
// depends on legarc_pkg
`timescale 1ns / 1ps

module legarc_ctrl
  import legarc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic [2:0]  sq_cnt;
  logic [2:0]  sq_cnt_next;
  div_job_t    job;
  div_job_t    job_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sq_cnt    <= '0;
      job       <= DJ_X;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sq_cnt    <= sq_cnt_next;
      job       <= job_next;
      out_valid <= cmd.emit || (out_valid && out_stall);
    end
  end

  always_comb begin
    state_next  = state;
    sq_cnt_next = sq_cnt;
    job_next    = job;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sq_cnt_next = '0;
          job_next    = DJ_X;
          // an empty move is taken and dropped
          if (!status.n_zero) state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sq_cnt == SQ_LAST) state_next = ST_DIV_START;
        else sq_cnt_next = sq_cnt + 3'd1;
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (job == DJ_AMP) begin
            state_next = ST_PH_MUL;
          end else begin
            job_next   = div_job_t'(job + 3'd1);
            state_next = ST_DIV_START;
          end
        end
      end
      ST_PH_MUL: state_next = ST_ROM;
      ST_ROM:    state_next = ST_ARC;
      ST_ARC:    state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = status.last ? ST_IDLE : ST_PH_MUL;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.sq_sel  = sq_sel_t'(sq_cnt[1:0]);
    cmd.div_job = job;
    in_stall    = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_SQUARE: begin
        cmd.sq_en  = sq_cnt != SQ_LAST;
        cmd.acc_en = sq_cnt != 3'd0;
        cmd.acc_h  = sq_cnt == SQ_LAST;
      end
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_DIV_WAIT:  cmd.div_start = 1'b0;
      ST_PH_MUL:    cmd.ph_mul = 1'b1;
      ST_ROM:       cmd.rom_rd = 1'b1;
      ST_ARC:       cmd.arc_mul = 1'b1;
      ST_OUT:       cmd.emit = out_free;
      default:      in_stall = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/leg_arc_trajectory_generator.sv =====
// leg_arc_trajectory_generator: top level - hop height register, APB port,
// sequencer and datapath; depends on legarc_pkg, legarc_ctrl, legarc_dp
//
// usage:
//   input channel (in_valid/in_stall) takes one move transaction: start and
//   goal points, step_count and arc_enable. output channel (out_valid/
//   out_stall) gives min(step_count, POINT_LIMIT) point transactions, the last
//   one flagged by last_point. a move with zero steps is taken and gives none.
//   the hop height register sits at APB address 0; it is to be written only
//   while idle, which the block itself does not enforce.
// operation:
//   each move first runs five divide jobs on the shared bit-serial divider
//   (NUMW = 2 * max(min(COORD_BITS+1, 32), 20) + 3, 53 at default widths);
//   each point then passes phase multiply, sine table read, arc multiply and
//   output. one move is worked at a time; in_stall is high from acceptance
//   until the last point is loaded into the output register.
// reset clears the sequencer, output valid and sets hop height to 25000.
// a stalled output holds its point; the sequencer waits in its output stage.
`timescale 1ns / 1ps

module leg_arc_trajectory_generator
  import legarc_pkg::*;
#(
  parameter int POINT_LIMIT      = 64,
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int COORD_BITS       = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] goal_x,
  input  logic signed [COORD_BITS-1:0] goal_y,
  input  logic signed [COORD_BITS-1:0] goal_z,
  input  logic [STEP_W-1:0]            step_count,
  input  logic                         arc_enable,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  output logic [IDX_W-1:0]             point_index,
  output logic                         last_point
);

  logic [HOP_W-1:0] hop_um;
  logic [HOP_W-1:0] hop_eff;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_um <= HOP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_HOP) begin
      hop_um <= pwdata[HOP_W-1:0];
    end
  end

  assign prdata  = (paddr[2] == REG_HOP) ? APB_DW'(hop_um) : '0;
  // zero height behaves as one micrometre
  assign hop_eff = (hop_um == '0) ? HOP_W'(1) : hop_um;

  legarc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  legarc_dp #(
    .POINT_LIMIT     (POINT_LIMIT),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .COORD_BITS      (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .start_x    (start_x),
    .start_y    (start_y),
    .start_z    (start_z),
    .goal_x     (goal_x),
    .goal_y     (goal_y),
    .goal_z     (goal_z),
    .step_count (step_count),
    .arc_enable (arc_enable),
    .hop_h      (hop_eff),
    .cmd        (cmd),
    .status     (status),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .point_index(point_index),
    .last_point (last_point)
  );

endmodule

// ===== rtl/core/legarc_chk.sv =====
// legarc_chk: port-level checks of the leg arc trajectory generator
// bound to leg_arc_trajectory_generator; depends on legarc_pkg
`timescale 1ns / 1ps

module legarc_chk
  import legarc_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [STEP_W-1:0]            step_count,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [COORD_BITS-1:0] point_x,
  input logic [IDX_W-1:0]             point_index,
  input logic                         last_point
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x))
    else $error("stalled point changed");

  a_busy_after_move: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && step_count != '0 |=> in_stall)
    else $error("move taken but input not stalled");

  // only the first point of a following move may come right after a last point
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_point |=> !out_valid || point_index == '0)
    else $error("point after last point of move");

  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_stall |-> last_point)
    else $error("idle while a move is unfinished");

endmodule

bind leg_arc_trajectory_generator legarc_chk #(.COORD_BITS(COORD_BITS)) u_chk (.*);
